>>> src/ddsqrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsqrt_pkg
// Types and constants for the decimal digit square root block.
// ----------------------------------------------------------------------------
package ddsqrt_pkg;

  localparam int unsigned RadicandW = 32;
  localparam int unsigned RootW     = 36;
  localparam int unsigned DecLimits = 9;

  typedef struct packed {
    logic [RadicandW-1:0] radicand;
    logic                 even_digit_count;
  } req_t;

  typedef struct packed {
    logic [RootW-1:0] root_millionths;
    logic             parity_error;
  } rsp_t;

  // 10^1 .. 10^9: a 32-bit value has one more decimal digit per limit it reaches
  localparam logic [RadicandW-1:0] DEC_LIMIT [1:DecLimits] = '{
    32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  function automatic logic [63:0] pow10(input int unsigned e);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < e; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

>>> src/decimal_digit_square_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_square_root
// floor(sqrt(radicand) * 10^FRAC_DIGITS), with a check of the digit parity flag.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. The radicand is
// scaled by 100 once per cycle, FRAC_DIGITS times, then a restoring
// binary square root unit makes one root bit per cycle, ROOT_BITS bits in
// all (36 at the default parameters). busy stays high throughout, and done_o
// pulses in the first cycle with busy low; a new start is taken in that same
// cycle. A wrong parity flag gives a zero root with parity_error set, with
// done_o in the next cycle and busy never raised. done_o is high for exactly
// one cycle and cannot be held off, so the receiver must take rsp_o in that
// cycle.
// ----------------------------------------------------------------------------
module decimal_digit_square_root #(
  parameter int unsigned FRAC_DIGITS   = 6,
  parameter int unsigned RADICAND_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ddsqrt_pkg::req_t   req_i,
  output logic               done_o,
  output ddsqrt_pkg::rsp_t   rsp_o
);

  localparam int unsigned InW       = (RADICAND_BITS < ddsqrt_pkg::RadicandW) ?
                                      RADICAND_BITS : ddsqrt_pkg::RadicandW;
  localparam logic [63:0] ScalePow  = ddsqrt_pkg::pow10(2 * FRAC_DIGITS);
  localparam int unsigned ScaleBits = $clog2(ScalePow);
  localparam int unsigned ROOT_BITS = (InW + ScaleBits + 1) / 2;
  localparam int unsigned NW        = 2 * ROOT_BITS;
  localparam int unsigned REM_W     = ROOT_BITS + 3;
  localparam int unsigned CntMax    = (FRAC_DIGITS > ROOT_BITS) ? FRAC_DIGITS : ROOT_BITS;
  localparam int unsigned CNT_W     = $clog2(CntMax + 1);
  localparam int unsigned WIDE_W    = (ROOT_BITS > ddsqrt_pkg::RootW) ?
                                      ROOT_BITS : ddsqrt_pkg::RootW;
  localparam logic [ddsqrt_pkg::RadicandW-1:0] InMask =
    ddsqrt_pkg::RadicandW'((64'd1 << InW) - 64'd1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_ROOT} state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   done_q;
  ddsqrt_pkg::rsp_t       rsp_q;

  logic [NW-1:0]          n_q, n_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [ROOT_BITS-1:0]   root_q, root_d;

  logic [ddsqrt_pkg::RadicandW-1:0] n_in;
  logic [ddsqrt_pkg::DecLimits-1:0] ge;
  logic                   is_even, par_err, take;
  logic [REM_W-1:0]       rem_sh, trial;
  logic [REM_W:0]         diff;
  logic                   fits;
  logic [NW-1:0]          scaled;
  logic [WIDE_W-1:0]      root_wide;

  assign take = start && !busy;
  assign n_in = req_i.radicand & InMask;

  always_comb begin
    for (int k = 1; k <= ddsqrt_pkg::DecLimits; k++) begin
      ge[k-1] = n_in >= ddsqrt_pkg::DEC_LIMIT[k];
    end
  end

  // digit count is 1 + popcount(ge): even when that popcount is odd
  assign is_even = ^ge;
  assign par_err = is_even != req_i.even_digit_count;

  assign scaled = (n_q << 6) + (n_q << 5) + (n_q << 2);

  // shared restoring square root step
  assign rem_sh = {rem_q[REM_W-3:0], n_q[NW-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign fits   = !diff[REM_W];

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (take) begin
      n_d    = NW'(n_in);
      rem_d  = '0;
      root_d = '0;
    end else if (state_q == ST_SCALE) begin
      n_d = scaled;
    end else if (state_q == ST_ROOT) begin
      n_d    = n_q << 2;
      rem_d  = fits ? diff[REM_W-1:0] : rem_sh;
      root_d = {root_q[ROOT_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_wide = WIDE_W'({root_q[ROOT_BITS-2:0], fits});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (par_err) begin
              done_q                <= 1'b1;
              rsp_q.root_millionths <= '0;
              rsp_q.parity_error    <= 1'b1;
            end else if (FRAC_DIGITS != 0) begin
              state_q <= ST_SCALE;
              cnt_q   <= CNT_W'(FRAC_DIGITS);
            end else begin
              state_q <= ST_ROOT;
              cnt_q   <= CNT_W'(ROOT_BITS);
            end
          end
        end
        ST_SCALE: begin
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_ROOT;
            cnt_q   <= CNT_W'(ROOT_BITS);
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_ROOT: begin
          if (cnt_q == CNT_W'(1)) begin
            state_q               <= ST_IDLE;
            done_q                <= 1'b1;
            rsp_q.root_millionths <= root_wide[ddsqrt_pkg::RootW-1:0];
            rsp_q.parity_error    <= 1'b0;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.parity_error |-> rsp_q.root_millionths == '0)
    else $error("parity error with nonzero root");

  a_err_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && par_err |=> done_q && !busy)
    else $error("parity error result not given next cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT |-> rem_q <= (REM_W'(root_q) << 1))
    else $error("square root remainder out of range");

endmodule
